// ===== rtl/nkbs_pkg.sv =====
package nkbs_pkg;

    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 10;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [INDEX_W-1:0]  t_index;

    localparam t_opcode OP_CLEAR  = 2'd0;
    localparam t_opcode OP_APPEND = 2'd1;
    localparam t_opcode OP_QUERY  = 2'd2;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_PROBE,
        ST_NEIGHBOR
    } t_state;

endpackage

// ===== rtl/nkbs_in_if.sv =====
interface nkbs_in_if #(
    parameter int KEY_BITS = 32
) ();
    logic                      valid;
    logic                      ready;
    nkbs_pkg::t_opcode         opcode;
    logic [KEY_BITS-1:0]       key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

// ===== rtl/nkbs_out_if.sv =====
interface nkbs_out_if #(
    parameter int KEY_BITS = 32
) ();
    logic                      valid;
    logic                      ready;
    nkbs_pkg::t_status         status;
    nkbs_pkg::t_index          entry_index;
    logic [KEY_BITS-1:0]       entry_key;

    modport source (output valid, output status, output entry_index, output entry_key,
                    input ready);
    modport sink   (input valid, input status, input entry_index, input entry_key,
                    output ready);
endinterface

// ===== rtl/nearest_key_binary_search.sv =====
// clear, append and unknown opcodes: result registered on the next edge
// query: reads the first entry, then the last, then P binary search probes, then a neighbor
//   when needed; it ends early once the result is known; P is at most ceil(log2(entry count))
// one item at a time: every probe is one read on the single read port of the key ram
// reset clears the state, the entry count and the output valid flag; key ram contents are left as is
module nearest_key_binary_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nkbs_in_if.sink           i_item,
    nkbs_out_if.source        o_result
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // control state
    nkbs_pkg::t_state        r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;

    // search registers
    logic [KEY_BITS-1:0]     r_key, n_key;
    logic [CNT_W-1:0]        r_lo, n_lo;
    logic [CNT_W-1:0]        r_hi, n_hi;
    logic [IDX_W-1:0]        r_mid, n_mid;
    logic [KEY_BITS-1:0]     r_midkey, n_midkey;
    logic [IDX_W-1:0]        r_nb, n_nb;
    logic                    r_up, n_up;

    // output register
    logic                    r_out_valid, n_out_valid;
    nkbs_pkg::t_status       r_status, n_status;
    logic [IDX_W-1:0]        r_res_idx, n_res_idx;
    logic [KEY_BITS-1:0]     r_res_key, n_res_key;

    // ram port
    logic                    wr_en;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [KEY_BITS-1:0]     rd_data;

    // probe decode
    logic                    key_gt, key_lt;
    logic [CNT_W-1:0]        mid_ext, lo_next, hi_next;
    logic [CNT_W:0]          mid_sum;
    logic                    stop;
    logic [KEY_BITS-1:0]     d_mid, d_nb;
    logic                    accept;

    nkbs_key_ram #(
        .DEPTH  (TABLE_DEPTH),
        .WIDTH  (KEY_BITS),
        .ADDR_W (IDX_W)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (i_item.key),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // new item only when idle and the output slot is free or emptying now
    assign i_item.ready = (r_state == nkbs_pkg::ST_IDLE) && (!r_out_valid || o_result.ready);
    assign accept       = i_item.valid && i_item.ready;

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_status;
    assign o_result.entry_index = nkbs_pkg::t_index'(r_res_idx);
    assign o_result.entry_key   = r_res_key;

    // compares against the word just read, shared by the first, last and probe states
    assign key_gt  = r_key > rd_data;
    assign key_lt  = r_key < rd_data;
    assign mid_ext = CNT_W'(r_mid);
    assign lo_next = key_gt ? (mid_ext + CNT_W'(1)) : r_lo;
    assign hi_next = key_gt ? r_hi : (mid_ext - CNT_W'(1));
    // a smaller key at entry 0 would move hi below zero, which ends the search
    assign stop    = (key_lt && (r_mid == '0)) || !(lo_next < hi_next);
    assign mid_sum = {1'b0, lo_next} + {1'b0, hi_next};

    // distances wrap at the key width
    assign d_mid = r_up ? (r_key - r_midkey) : (r_midkey - r_key);
    assign d_nb  = r_up ? (rd_data - r_key) : (r_key - rd_data);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_midkey    = r_midkey;
        n_nb        = r_nb;
        n_up        = r_up;
        n_out_valid = r_out_valid && !o_result.ready;
        n_status    = r_status;
        n_res_idx   = r_res_idx;
        n_res_key   = r_res_key;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;

        case (r_state)
            nkbs_pkg::ST_IDLE: begin
                if (accept) begin
                    n_key     = i_item.key;
                    n_status  = nkbs_pkg::STATUS_OK;
                    n_res_idx = '0;
                    n_res_key = '0;
                    case (i_item.opcode)
                        nkbs_pkg::OP_CLEAR: begin
                            n_count     = '0;
                            n_out_valid = 1'b1;
                        end
                        nkbs_pkg::OP_APPEND: begin
                            if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                                n_status = nkbs_pkg::STATUS_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                            n_out_valid = 1'b1;
                        end
                        nkbs_pkg::OP_QUERY: begin
                            if (r_count == '0) begin
                                n_status    = nkbs_pkg::STATUS_EMPTY;
                                n_out_valid = 1'b1;
                            end else begin
                                // first entry
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_state = nkbs_pkg::ST_FIRST;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end

            nkbs_pkg::ST_FIRST: begin
                if (r_count == CNT_W'(1) || key_lt) begin
                    n_res_idx   = '0;
                    n_res_key   = rd_data;
                    n_out_valid = 1'b1;
                    n_state     = nkbs_pkg::ST_IDLE;
                end else begin
                    // last entry
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(r_count - CNT_W'(1));
                    n_state = nkbs_pkg::ST_LAST;
                end
            end

            nkbs_pkg::ST_LAST: begin
                if (key_gt) begin
                    n_res_idx   = IDX_W'(r_count - CNT_W'(1));
                    n_res_key   = rd_data;
                    n_out_valid = 1'b1;
                    n_state     = nkbs_pkg::ST_IDLE;
                end else begin
                    // at least two entries, so the search takes one probe or more
                    n_lo    = '0;
                    n_hi    = r_count - CNT_W'(1);
                    n_mid   = IDX_W'((r_count - CNT_W'(1)) >> 1);
                    rd_en   = 1'b1;
                    rd_addr = n_mid;
                    n_state = nkbs_pkg::ST_PROBE;
                end
            end

            nkbs_pkg::ST_PROBE: begin
                if (!key_gt && !key_lt) begin
                    n_res_idx   = r_mid;
                    n_res_key   = rd_data;
                    n_out_valid = 1'b1;
                    n_state     = nkbs_pkg::ST_IDLE;
                end else if (!stop) begin
                    n_lo    = lo_next;
                    n_hi    = hi_next;
                    n_mid   = IDX_W'(mid_sum >> 1);
                    rd_en   = 1'b1;
                    rd_addr = n_mid;
                end else begin
                    n_midkey = rd_data;
                    n_up     = key_gt;
                    if (key_gt && (mid_ext + CNT_W'(1) >= r_count)) begin
                        // no upper neighbor
                        n_res_idx   = r_mid;
                        n_res_key   = rd_data;
                        n_out_valid = 1'b1;
                        n_state     = nkbs_pkg::ST_IDLE;
                    end else if (key_lt && (r_mid == '0)) begin
                        // no lower neighbor
                        n_res_idx   = r_mid;
                        n_res_key   = rd_data;
                        n_out_valid = 1'b1;
                        n_state     = nkbs_pkg::ST_IDLE;
                    end else begin
                        n_nb    = key_gt ? (r_mid + IDX_W'(1)) : (r_mid - IDX_W'(1));
                        rd_en   = 1'b1;
                        rd_addr = n_nb;
                        n_state = nkbs_pkg::ST_NEIGHBOR;
                    end
                end
            end

            nkbs_pkg::ST_NEIGHBOR: begin
                // tie goes to the neighbor
                if (d_mid < d_nb) begin
                    n_res_idx = r_mid;
                    n_res_key = r_midkey;
                end else begin
                    n_res_idx = r_nb;
                    n_res_key = rd_data;
                end
                n_out_valid = 1'b1;
                n_state     = nkbs_pkg::ST_IDLE;
            end

            default: begin
                n_state = nkbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nkbs_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_midkey  <= n_midkey;
        r_nb      <= n_nb;
        r_up      <= n_up;
        r_status  <= n_status;
        r_res_idx <= n_res_idx;
        r_res_key <= n_res_key;
    end

endmodule

// ===== rtl/nkbs_key_ram.sv =====
module nkbs_key_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int TABLE_DEPTH   = 1024;
    localparam int KEY_BITS      = 32;
    localparam int TOTAL_ITEMS   = 1300;     // sends at least this many items, the full fill included
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 1_500_000;

    // opcode that the block does not decode
    localparam nkbs_pkg::t_opcode OP_SPARE = 2'd3;

    typedef logic [KEY_BITS-1:0] t_key;

    // one result item as the block should return it
    typedef struct {
        nkbs_pkg::t_status status;
        nkbs_pkg::t_index  entry_index;
        t_key              entry_key;
    } t_lookup;

    // shadow copy of the key table, nearest-key prediction and result checking
    class lookup_scoreboard;
        t_key    table_keys [TABLE_DEPTH];
        int      key_count;
        t_lookup awaited [$];
        int      mismatches;

        function new();
            key_count  = 0;
            mismatches = 0;
        endfunction

        // midpoint search, then end checks against the last probed entry's neighbor
        function int nearest_entry(t_key key);
            int   lo;
            int   hi;
            int   mid;
            t_key mid_key;
            t_key d_mid;
            t_key d_nb;
            lo  = 0;
            hi  = key_count - 1;
            mid = 0;
            if (key_count == 1) return 0;
            if (key < table_keys[0]) return 0;
            if (key > table_keys[key_count-1]) return key_count - 1;
            mid_key = table_keys[0];
            while (lo < hi) begin
                mid     = (lo + hi) / 2;
                mid_key = table_keys[mid];
                if (key > mid_key) lo = mid + 1;
                else if (key < mid_key) hi = mid - 1;
                else return mid;
            end
            // distances wrap at the key width, ties go to the neighbor
            if (key > mid_key) begin
                if (mid + 1 >= key_count) return mid;
                d_mid = key - mid_key;
                d_nb  = table_keys[mid+1] - key;
                return (d_mid < d_nb) ? mid : mid + 1;
            end
            if (key < mid_key) begin
                if (mid < 1) return mid;
                d_mid = mid_key - key;
                d_nb  = key - table_keys[mid-1];
                return (d_mid < d_nb) ? mid : mid - 1;
            end
            return mid;
        endfunction

        function void note_item(nkbs_pkg::t_opcode op, t_key key);
            t_lookup res;
            int      idx;
            res = '{nkbs_pkg::STATUS_OK, '0, '0};
            case (op)
                nkbs_pkg::OP_CLEAR: begin
                    key_count = 0;
                end
                nkbs_pkg::OP_APPEND: begin
                    if (key_count >= TABLE_DEPTH) begin
                        res.status = nkbs_pkg::STATUS_FULL;
                    end else begin
                        table_keys[key_count] = key;
                        key_count++;
                    end
                end
                nkbs_pkg::OP_QUERY: begin
                    if (key_count == 0) begin
                        res.status = nkbs_pkg::STATUS_EMPTY;
                    end else begin
                        idx             = nearest_entry(key);
                        res.entry_index = nkbs_pkg::t_index'(idx);
                        res.entry_key   = table_keys[idx];
                    end
                end
                default: ;
            endcase
            awaited.insert(awaited.size(), res);
        endfunction

        function void check_result(nkbs_pkg::t_status status, nkbs_pkg::t_index idx,
                                   t_key key);
            t_lookup exp;
            if (awaited.size() == 0) begin
                mismatches++;
                $display("%0t: result with none pending: status %0d index %0d key %h",
                         $time, status, idx, key);
                return;
            end
            exp = awaited.pop_front();
            if (status !== exp.status || idx !== exp.entry_index || key !== exp.entry_key) begin
                mismatches++;
                $display("%0t: expected status/index/key %0d/%0d/%h, got %0d/%0d/%h",
                         $time, exp.status, exp.entry_index, exp.entry_key,
                         status, idx, key);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    nkbs_in_if  #(.KEY_BITS(KEY_BITS)) item_if ();
    nkbs_out_if #(.KEY_BITS(KEY_BITS)) result_if ();

    nearest_key_binary_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    lookup_scoreboard sb = new();

    int items_sent  = 0;
    int cycle_count = 0;
    bit no_idle     = 1'b0;  // stretch with no gaps on either side

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[nearest_key_binary_search] ERROR");
            $finish;
        end
    end

    // result side: every accepted result goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
            sb.check_result(result_if.status, result_if.entry_index, result_if.entry_key);
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: bursts of ready with random stalls between them
    initial begin
        result_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            repeat ($urandom_range(1, 30)) begin
                @(negedge i_clk);
                result_if.ready = 1'b1;
            end
            repeat (no_idle ? 0 : pick_gap()) begin
                @(negedge i_clk);
                result_if.ready = 1'b0;
            end
        end
    end

    // sender idle for some cycles, junk on the payload while valid is low
    task automatic pause_sender(int cycles);
        @(negedge i_clk);
        item_if.valid  = 1'b0;
        item_if.opcode = nkbs_pkg::t_opcode'($urandom_range(0, 3));
        item_if.key    = $urandom;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // one item, held until accepted, then handed to the scoreboard
    task automatic send_item(nkbs_pkg::t_opcode op, t_key key);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) pause_sender(gap);
        @(negedge i_clk);
        item_if.valid  = 1'b1;
        item_if.opcode = op;
        item_if.key    = key;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        sb.note_item(op, key);
        items_sent++;
    endtask

    // hold the sender until every pending result is back
    task automatic wait_for_results();
        @(negedge i_clk);
        item_if.valid = 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    // query keys aimed at the table: hits, near misses, midpoints and both ends
    function automatic t_key query_key();
        int               i;
        t_key             a;
        t_key             b;
        t_key             first_key;
        t_key             last_key;
        logic [KEY_BITS:0] sum;
        if (sb.key_count == 0) return $urandom;
        i         = $urandom_range(0, sb.key_count - 1);
        a         = sb.table_keys[i];
        b         = (i + 1 < sb.key_count) ? sb.table_keys[i+1] : a;
        first_key = sb.table_keys[0];
        last_key  = sb.table_keys[sb.key_count-1];
        case ($urandom_range(0, 11))
            0, 1: return a;
            2: return a + 1'b1;
            3: return a - 1'b1;
            4: begin
                sum = {1'b0, a} + b;
                return sum[KEY_BITS:1];
            end
            5: begin
                // upper midpoint, lands on a tie only for even gaps
                sum = {1'b0, a} + b + 1'b1;
                return sum[KEY_BITS:1];
            end
            6: return '0;
            7: return '1;
            8: return (first_key == '0) ? '0 : $urandom_range(0, first_key - 1'b1);
            9: return (last_key == '1) ? '1 :
                      $urandom_range(last_key + 1'b1, {KEY_BITS{1'b1}});
            10: return $urandom_range(first_key, last_key);
            default: return $urandom;
        endcase
    endfunction

    // n keys in ascending order, spacing tight (duplicates), moderate or wide
    task automatic append_ascending(int n);
        longint unsigned next_key;
        longint unsigned step_max;
        longint unsigned step_cap;
        case ($urandom_range(0, 2))
            0: next_key = 0;
            1: next_key = $urandom_range(0, 1000);
            default: next_key = $urandom;
        endcase
        step_max = (64'hFFFF_FFFF - next_key) / n;
        case ($urandom_range(0, 2))
            0: step_cap = 3;
            1: step_cap = 1000;
            default: step_cap = step_max;
        endcase
        if (step_cap > step_max) step_cap = step_max;
        for (int k = 0; k < n; k++) begin
            send_item(nkbs_pkg::OP_APPEND, t_key'(next_key));
            next_key += $urandom_range(0, 32'(step_cap));
        end
    endtask

    // usual case: clear (most of the time), sorted fill of mostly small size, then a run of queries
    task automatic table_episode();
        int r;
        int n;
        if ($urandom_range(0, 9) != 0) send_item(nkbs_pkg::OP_CLEAR, $urandom);
        r = $urandom_range(0, 99);
        if (r < 70) n = $urandom_range(1, 12);
        else if (r < 95) n = $urandom_range(13, 64);
        else n = $urandom_range(65, 300);
        append_ascending(n);
        if ($urandom_range(0, 9) == 0) wait_for_results();
        repeat ($urandom_range(4, 24)) send_item(nkbs_pkg::OP_QUERY, query_key());
    endtask

    // any opcode, any key: unsorted tables, stray clears, the unused opcode
    task automatic noise_burst();
        repeat ($urandom_range(1, 20))
            send_item(nkbs_pkg::t_opcode'($urandom_range(0, 3)), $urandom);
    endtask

    // fill every entry, push past full, then search the deepest table
    task automatic full_table_episode();
        longint unsigned next_key;
        send_item(nkbs_pkg::OP_CLEAR, '0);
        next_key = $urandom_range(0, 100);
        repeat (TABLE_DEPTH) begin
            send_item(nkbs_pkg::OP_APPEND, t_key'(next_key));
            next_key += $urandom_range(1, 4_000_000);
        end
        repeat (3) send_item(nkbs_pkg::OP_APPEND, $urandom);
        wait_for_results();
        repeat (40) send_item(nkbs_pkg::OP_QUERY, query_key());
        send_item(nkbs_pkg::OP_QUERY, '0);
        send_item(nkbs_pkg::OP_QUERY, '1);
    endtask

    initial begin
        bit full_done;
        full_done      = 1'b0;
        i_rst_n        = 1'b0;
        item_if.valid  = 1'b0;
        item_if.opcode = nkbs_pkg::OP_CLEAR;
        item_if.key    = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty table, unused opcode, single entry
        send_item(nkbs_pkg::OP_QUERY, '0);
        send_item(OP_SPARE, '1);
        send_item(nkbs_pkg::OP_APPEND, 32'h8000_0000);
        send_item(nkbs_pkg::OP_QUERY, '0);
        send_item(nkbs_pkg::OP_QUERY, '1);

        // directed: both key extremes stored, exact hits at each end, ties, a query in the wide top gap
        send_item(nkbs_pkg::OP_CLEAR, 32'h5A5A_A5A5);
        send_item(nkbs_pkg::OP_APPEND, 32'd0);
        send_item(nkbs_pkg::OP_APPEND, 32'd10);
        send_item(nkbs_pkg::OP_APPEND, 32'd20);
        send_item(nkbs_pkg::OP_APPEND, 32'd30);
        send_item(nkbs_pkg::OP_APPEND, 32'hFFFF_FFFF);
        send_item(nkbs_pkg::OP_QUERY, 32'd0);
        send_item(nkbs_pkg::OP_QUERY, 32'hFFFF_FFFF);
        send_item(nkbs_pkg::OP_QUERY, 32'd15);
        send_item(nkbs_pkg::OP_QUERY, 32'd25);
        send_item(nkbs_pkg::OP_QUERY, 32'd26);
        send_item(nkbs_pkg::OP_QUERY, 32'd30);
        send_item(nkbs_pkg::OP_QUERY, 32'h7FFF_FFFF);

        // directed: query below the first key and above the last key
        send_item(nkbs_pkg::OP_CLEAR, '0);
        send_item(nkbs_pkg::OP_APPEND, 32'd5);
        send_item(nkbs_pkg::OP_APPEND, 32'd100);
        send_item(nkbs_pkg::OP_QUERY, 32'd0);
        send_item(nkbs_pkg::OP_QUERY, 32'd200);

        wait_for_results();

        // random: mostly well-formed tables and queries, some noise, one full fill early on
        while (items_sent < TOTAL_ITEMS) begin
            no_idle = ($urandom_range(0, 6) == 0);
            if (!full_done && items_sent >= TOTAL_ITEMS / 5) begin
                full_table_episode();
                full_done = 1'b1;
            end else if ($urandom_range(0, 99) < 10) begin
                noise_burst();
            end else begin
                table_episode();
            end
        end

        // drain, then give late or extra results a chance to show up
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("[nearest_key_binary_search] OK");
        else
            $display("[nearest_key_binary_search] ERROR");
        $finish;
    end

endmodule

// ===== nearest_key_binary_search.f =====
rtl/nkbs_pkg.sv
rtl/nkbs_in_if.sv
rtl/nkbs_out_if.sv
rtl/nkbs_key_ram.sv
rtl/nearest_key_binary_search.sv
tb/tb.sv
